// ----- hdl/tmaf_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the trimmed-mean converter filter.
// No dependencies; used by the front, queue, back and top level.
package tmaf_pkg;

  localparam int SAMPLE_W    = 12;
  localparam int SUM_W       = 18;
  localparam int COUNT_W     = 6;
  localparam int REF_W       = 13;
  localparam int SCALE_SHIFT = 12;
  localparam int MEAN_SHIFT  = 24;
  localparam int MV_SHIFT    = 25;

  localparam logic [REF_W-1:0]    REF_RESET  = 13'd3300;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'hFFF;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic                ch;
    logic [SUM_W-1:0]    sum;
    logic [SAMPLE_W-1:0] max_code;
    logic [SAMPLE_W-1:0] min_code;
  } win_t;

endpackage

// ----- hdl/tmaf_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts samples and keeps per-channel sum, max, min and count.
// Depends on tmaf_pkg; pushes completed window records into tmaf_queue.
module tmaf_front #(
  parameter int WINDOW   = 30,
  parameter int CHANNELS = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          channel_id_i,
  input  logic [tmaf_pkg::SAMPLE_W-1:0] sample_code_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output tmaf_pkg::win_t                win_o
);

  localparam int LIVE = (CHANNELS < 2) ? CHANNELS : 2;

  logic [tmaf_pkg::SUM_W-1:0]    sum_q   [LIVE];
  logic [tmaf_pkg::SAMPLE_W-1:0] max_q   [LIVE];
  logic [tmaf_pkg::SAMPLE_W-1:0] min_q   [LIVE];
  logic [tmaf_pkg::COUNT_W-1:0]  count_q [LIVE];

  logic [LIVE-1:0]               hit;
  logic                          accept;
  logic [tmaf_pkg::SUM_W-1:0]    cur_sum, sum_d;
  logic [tmaf_pkg::SAMPLE_W-1:0] cur_max, cur_min, max_d, min_d;
  logic [tmaf_pkg::COUNT_W-1:0]  cur_count, count_d;
  logic                          done;

  assign accept = in_valid_i && !q_full_i;

  always_comb begin
    cur_sum   = '0;
    cur_max   = '0;
    cur_min   = '0;
    cur_count = '0;
    for (int g = 0; g < LIVE; g++) begin
      hit[g] = (channel_id_i == 1'(g));
      if (hit[g]) begin
        cur_sum   = sum_q[g];
        cur_max   = max_q[g];
        cur_min   = min_q[g];
        cur_count = count_q[g];
      end
    end
    max_d   = (sample_code_i > cur_max) ? sample_code_i : cur_max;
    min_d   = (sample_code_i < cur_min) ? sample_code_i : cur_min;
    sum_d   = cur_sum + tmaf_pkg::SUM_W'(sample_code_i);
    count_d = cur_count + tmaf_pkg::COUNT_W'(1);
    done    = (count_d == tmaf_pkg::COUNT_W'(WINDOW));
  end

  assign push_o         = accept && (|hit) && done;
  assign win_o.ch       = channel_id_i;
  assign win_o.sum      = sum_d;
  assign win_o.max_code = max_d;
  assign win_o.min_code = min_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < LIVE; g++) begin
        sum_q[g]   <= '0;
        max_q[g]   <= '0;
        min_q[g]   <= tmaf_pkg::SAMPLE_MAX;
        count_q[g] <= '0;
      end
    end else begin
      for (int g = 0; g < LIVE; g++) begin
        if (accept && hit[g]) begin
          if (done) begin
            sum_q[g]   <= '0;
            max_q[g]   <= '0;
            min_q[g]   <= tmaf_pkg::SAMPLE_MAX;
            count_q[g] <= '0;
          end else begin
            sum_q[g]   <= sum_d;
            max_q[g]   <= max_d;
            min_q[g]   <= min_d;
            count_q[g] <= count_d;
          end
        end
      end
    end
  end

endmodule

// ----- hdl/tmaf_queue.sv -----
`timescale 1ns / 1ps
// Short queue of completed window records between front and back.
// Depends on tmaf_pkg for the record type and depth.
module tmaf_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tmaf_pkg::win_t win_i,
  input  logic           pop_i,
  output logic           valid_o,
  output logic           full_o,
  output tmaf_pkg::win_t win_o
);

  tmaf_pkg::win_t                 mem_q [tmaf_pkg::QUEUE_DEPTH];
  logic [tmaf_pkg::QPTR_W-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [tmaf_pkg::QCNT_W-1:0]    cnt_q, cnt_d;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == tmaf_pkg::QCNT_W'(tmaf_pkg::QUEUE_DEPTH));
  assign win_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + tmaf_pkg::QPTR_W'(1) : wr_q;
    rd_d  = pop_i ? rd_q + tmaf_pkg::QPTR_W'(1) : rd_q;
    cnt_d = cnt_q + tmaf_pkg::QCNT_W'(push_i) - tmaf_pkg::QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= win_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("window record pushed into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("window record popped from empty queue");
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + tmaf_pkg::QCNT_W'(1))
    else $error("queue fill count did not advance on push");
`endif

endmodule

// ----- hdl/tmaf_back.sv -----
`timescale 1ns / 1ps
// Back end: trims a window record, divides by WINDOW-2 and scales to millivolts.
// Depends on tmaf_pkg; pops records from tmaf_queue and drives the result word.
module tmaf_back #(
  parameter int WINDOW = 30
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [tmaf_pkg::REF_W-1:0]    ref_i,
  input  logic                          q_valid_i,
  input  tmaf_pkg::win_t                q_win_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          result_channel_o,
  output logic [tmaf_pkg::SAMPLE_W-1:0] mean_code_o,
  output logic [tmaf_pkg::REF_W-1:0]    voltage_millivolts_o
);

  localparam int DIV      = WINDOW - 2;
  localparam int MREC_W   = tmaf_pkg::MEAN_SHIFT + 1;
  localparam int VREC_W   = tmaf_pkg::MV_SHIFT + 1;
  localparam int PROD_W   = tmaf_pkg::SUM_W + tmaf_pkg::REF_W;
  localparam int SCALED_W = PROD_W - tmaf_pkg::SCALE_SHIFT;
  localparam int MPROD_W  = tmaf_pkg::SUM_W + MREC_W;
  localparam int VDIV_W   = SCALED_W + VREC_W;
  localparam logic [MREC_W-1:0] MEAN_RECIP =
    MREC_W'((2 ** tmaf_pkg::MEAN_SHIFT + DIV - 1) / DIV);
  localparam logic [VREC_W-1:0] MV_RECIP =
    VREC_W'((2 ** tmaf_pkg::MV_SHIFT + DIV - 1) / DIV);

  logic                                  v1_q, v2_q, v3_q, v4_q;
  logic                                  rdy1, rdy2, rdy3, rdy4;
  logic                                  ch1_q, ch2_q, ch3_q, ch4_q;
  logic [tmaf_pkg::SUM_W-1:0]            trim_d, trim_q;
  logic [MPROD_W-1:0]                    mprod_q;
  logic [PROD_W-1:0]                     vprod_q;
  logic [tmaf_pkg::SAMPLE_W-1:0]         mean3_q, mean4_q;
  logic [VDIV_W-1:0]                     vdiv_q;
  logic [tmaf_pkg::REF_W-1:0]            mv4_q;

  assign rdy4  = !v4_q || !out_stall_i;
  assign rdy3  = !v3_q || rdy4;
  assign rdy2  = !v2_q || rdy3;
  assign rdy1  = !v1_q || rdy2;
  assign pop_o = q_valid_i && rdy1;

  assign trim_d = q_win_i.sum - tmaf_pkg::SUM_W'(q_win_i.max_code)
                              - tmaf_pkg::SUM_W'(q_win_i.min_code);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= q_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      ch1_q  <= q_win_i.ch;
      trim_q <= trim_d;
    end
    if (rdy2) begin
      ch2_q   <= ch1_q;
      mprod_q <= MPROD_W'(trim_q) * MPROD_W'(MEAN_RECIP);
      vprod_q <= PROD_W'(trim_q) * PROD_W'(ref_i);
    end
    if (rdy3) begin
      ch3_q   <= ch2_q;
      mean3_q <= mprod_q[tmaf_pkg::MEAN_SHIFT +: tmaf_pkg::SAMPLE_W];
      vdiv_q  <= VDIV_W'(vprod_q[PROD_W-1:tmaf_pkg::SCALE_SHIFT]) * VDIV_W'(MV_RECIP);
    end
    if (rdy4) begin
      ch4_q   <= ch3_q;
      mean4_q <= mean3_q;
      mv4_q   <= vdiv_q[tmaf_pkg::MV_SHIFT +: tmaf_pkg::REF_W];
    end
  end

  assign out_valid_o          = v4_q;
  assign result_channel_o     = ch4_q;
  assign mean_code_o          = mean4_q;
  assign voltage_millivolts_o = mv4_q;

endmodule

// ----- hdl/trimmed_mean_adc_filter.sv -----
`timescale 1ns / 1ps
// Trimmed-mean converter filter, top level: register, front, queue and back.
// Depends on tmaf_pkg, tmaf_front, tmaf_queue and tmaf_back.
//
// Takes one 12-bit sample word per clock while in_stall_o is low, tagged with
// a channel; samples of a channel at or above CHANNELS are dropped. After
// WINDOW samples of a channel one largest and one smallest are removed and a
// word with the channel, the floored mean code and the floored millivolt
// value is emitted; that channel's window then restarts. Sample intake is one
// word per cycle while the queue is not full; each accepted word updates the
// per-channel sum, max, min and count. A completed window passes through the
// queue, then the trim, multiply, reciprocal multiply and output registers. A
// four-entry queue of completed windows sits between intake and arithmetic, so
// an output stall holds back intake only once the queue is full. Write
// reference_millivolts only while no window is in flight.
module trimmed_mean_adc_filter #(
  parameter int WINDOW   = 30,
  parameter int CHANNELS = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tmaf_pkg::REF_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          channel_id_i,
  input  logic [tmaf_pkg::SAMPLE_W-1:0] sample_code_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          result_channel_o,
  output logic [tmaf_pkg::SAMPLE_W-1:0] mean_code_o,
  output logic [tmaf_pkg::REF_W-1:0]    voltage_millivolts_o
);

  logic [tmaf_pkg::REF_W-1:0] ref_q;
  logic                       push, pop, q_valid, q_full;
  tmaf_pkg::win_t             push_win, q_win;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= tmaf_pkg::REF_RESET;
    end else if (cfg_we_i) begin
      ref_q <= cfg_wdata_i;
    end
  end

  assign in_stall_o = q_full;

  tmaf_front #(
    .WINDOW   (WINDOW),
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .channel_id_i  (channel_id_i),
    .sample_code_i (sample_code_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .win_o         (push_win)
  );

  tmaf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .win_i   (push_win),
    .pop_i   (pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .win_o   (q_win)
  );

  tmaf_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .ref_i                (ref_q),
    .q_valid_i            (q_valid),
    .q_win_i              (q_win),
    .pop_o                (pop),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .result_channel_o     (result_channel_o),
    .mean_code_o          (mean_code_o),
    .voltage_millivolts_o (voltage_millivolts_o)
  );

endmodule

// ----- verif/trimmed_mean_adc_filter_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for trimmed_mean_adc_filter: directed and random sample words, each
// completed window predicted and compared word by word with the result outputs.
// Depends on tmaf_pkg and the trimmed_mean_adc_filter RTL.
module trimmed_mean_adc_filter_test;

  localparam int WINDOW        = 30;
  localparam int CHANNELS      = 2;
  localparam int TRIM_DIV      = WINDOW - 2;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int N_ROWS        = 11;

  typedef struct {
    logic                          ch;
    logic [tmaf_pkg::SAMPLE_W-1:0] mean;
    logic [tmaf_pkg::REF_W-1:0]    mv;
  } mean_word_t;

  typedef struct {
    logic                          wr_cfg;
    logic [tmaf_pkg::REF_W-1:0]    cfg;
    logic                          ch;
    logic [tmaf_pkg::SAMPLE_W-1:0] base;
    logic [tmaf_pkg::SAMPLE_W-1:0] hi;
    logic [tmaf_pkg::SAMPLE_W-1:0] lo;
    int                            hi_at;
    int                            lo_at;
    logic                          typed;
    logic [tmaf_pkg::SAMPLE_W-1:0] t_mean;
    logic [tmaf_pkg::REF_W-1:0]    t_mv;
  } window_row_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [tmaf_pkg::REF_W-1:0]    cfg_wdata_i;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic                          channel_id_i;
  logic [tmaf_pkg::SAMPLE_W-1:0] sample_code_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic                          result_channel_o;
  logic [tmaf_pkg::SAMPLE_W-1:0] mean_code_o;
  logic [tmaf_pkg::REF_W-1:0]    voltage_millivolts_o;

  logic [tmaf_pkg::SUM_W-1:0]    win_sum  [CHANNELS];
  logic [tmaf_pkg::SAMPLE_W-1:0] win_hi   [CHANNELS];
  logic [tmaf_pkg::SAMPLE_W-1:0] win_lo   [CHANNELS];
  logic [tmaf_pkg::COUNT_W-1:0]  win_fill [CHANNELS];
  logic [tmaf_pkg::REF_W-1:0]    scale_mv;

  mean_word_t awaited_means [$];
  int         mismatch_cnt;
  int         send_idle_pct;
  int         recv_stall_pct;
  bit         hold_req;

  trimmed_mean_adc_filter #(
    .WINDOW  (WINDOW),
    .CHANNELS(CHANNELS)
  ) i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .channel_id_i        (channel_id_i),
    .sample_code_i       (sample_code_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .result_channel_o    (result_channel_o),
    .mean_code_o         (mean_code_o),
    .voltage_millivolts_o(voltage_millivolts_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  initial begin
    #8_000_000;
    $display("trimmed_mean_adc_filter_test: errors");
    $finish;
  end

  task automatic clear_window(input int ch);
    win_sum[ch]  = '0;
    win_hi[ch]   = '0;
    win_lo[ch]   = tmaf_pkg::SAMPLE_MAX;
    win_fill[ch] = '0;
  endtask

  task automatic fold_sample(input logic ch, input logic [tmaf_pkg::SAMPLE_W-1:0] code,
                             input logic typed, input mean_word_t typed_word);
    int unsigned       trimmed;
    longint unsigned   scaled;
    mean_word_t        w;
    if (code > win_hi[ch]) win_hi[ch] = code;
    if (code < win_lo[ch]) win_lo[ch] = code;
    win_sum[ch]  = win_sum[ch] + code;
    win_fill[ch] = win_fill[ch] + 1'b1;
    if (win_fill[ch] == WINDOW) begin
      trimmed = 32'(win_sum[ch]) - 32'(win_hi[ch]) - 32'(win_lo[ch]);
      scaled  = 64'(trimmed) * 64'(scale_mv);
      w.ch    = ch;
      w.mean  = tmaf_pkg::SAMPLE_W'(trimmed / TRIM_DIV);
      w.mv    = tmaf_pkg::REF_W'(scaled / (TRIM_DIV * 4096));
      if (typed) w = typed_word;
      awaited_means.push_back(w);
      clear_window(ch);
    end
  endtask

  task automatic send_word(input logic ch, input logic [tmaf_pkg::SAMPLE_W-1:0] code,
                           input logic typed, input mean_word_t typed_word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    channel_id_i  <= ch;
    sample_code_i <= code;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    fold_sample(ch, code, typed, typed_word);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (awaited_means.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_scale(input logic [tmaf_pkg::REF_W-1:0] value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    scale_mv     = value;
  endtask

  // result side: check accepted words, then decide the next stall
  initial begin
    int         hold_left;
    mean_word_t want;
    out_stall_i = 1'b0;
    hold_left   = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (awaited_means.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected word: ch %0d mean %0d mv %0d",
                     result_channel_o, mean_code_o, voltage_millivolts_o);
        end else begin
          want = awaited_means.pop_front();
          if (want.ch !== result_channel_o || want.mean !== mean_code_o ||
              want.mv !== voltage_millivolts_o) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display({"mismatch: expected ch %0d mean %0d mv %0d, ",
                        "got ch %0d mean %0d mv %0d"},
                       want.ch, want.mean, want.mv,
                       result_channel_o, mean_code_o, voltage_millivolts_o);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin
    window_row_t                   rows [N_ROWS];
    mean_word_t                    row_word;
    mean_word_t                    no_word;
    int                            phase;
    int                            n_items;
    int                            level;
    int                            ch_bias;
    int                            pick;
    int                            v;
    logic [tmaf_pkg::REF_W-1:0]    scale_pick;
    logic [tmaf_pkg::SAMPLE_W-1:0] code;
    logic                          ch;

    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    channel_id_i   = 1'b0;
    sample_code_i  = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    mismatch_cnt   = 0;
    scale_mv       = tmaf_pkg::REF_RESET;
    no_word        = '{1'b0, '0, '0};
    for (int c = 0; c < CHANNELS; c++) clear_window(c);

    // wr_cfg, cfg, ch, base, hi, lo, hi_at, lo_at, typed, mean, mv
    rows[0]  = '{1'b0, 13'd0,    1'b0, 12'd4095, 12'd4095, 12'd4095, 0,  1,  1'b1,
                 12'd4095, 13'd3299};
    rows[1]  = '{1'b0, 13'd0,    1'b1, 12'd0,    12'd0,    12'd0,    0,  1,  1'b1,
                 12'd0,    13'd0};
    rows[2]  = '{1'b1, 13'd4096, 1'b0, 12'd4095, 12'd4095, 12'd4095, 0,  1,  1'b1,
                 12'd4095, 13'd4095};
    rows[3]  = '{1'b0, 13'd0,    1'b1, 12'd1000, 12'd4095, 12'd0,    0,  29, 1'b1,
                 12'd1000, 13'd1000};
    rows[4]  = '{1'b1, 13'd0,    1'b0, 12'd4095, 12'd4095, 12'd4095, 5,  6,  1'b1,
                 12'd4095, 13'd0};
    rows[5]  = '{1'b1, 13'd1000, 1'b1, 12'd2048, 12'd4095, 12'd0,    29, 0,  1'b1,
                 12'd2048, 13'd500};
    rows[6]  = '{1'b1, 13'd8191, 1'b0, 12'd4095, 12'd4095, 12'd4095, 0,  1,  1'b0,
                 12'd0,    13'd0};
    rows[7]  = '{1'b1, 13'd5000, 1'b1, 12'hAAA,  12'hFFF,  12'h555,  14, 15, 1'b0,
                 12'd0,    13'd0};
    rows[8]  = '{1'b0, 13'd0,    1'b0, 12'h555,  12'hAAA,  12'h000,  3,  20, 1'b0,
                 12'd0,    13'd0};
    rows[9]  = '{1'b1, 13'd1,    1'b1, 12'h001,  12'h800,  12'h001,  7,  8,  1'b0,
                 12'd0,    13'd0};
    rows[10] = '{1'b0, 13'd0,    1'b0, 12'd2000, 12'd100,  12'd3000, 10, 11, 1'b0,
                 12'd0,    13'd0};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < N_ROWS; r++) begin
      if (rows[r].wr_cfg) write_scale(rows[r].cfg);
      row_word = '{rows[r].ch, rows[r].t_mean, rows[r].t_mv};
      for (int i = 0; i < WINDOW; i++) begin
        if (i == rows[r].hi_at)      code = rows[r].hi;
        else if (i == rows[r].lo_at) code = rows[r].lo;
        else                         code = rows[r].base;
        send_word(rows[r].ch, code, rows[r].typed && (i == WINDOW - 1), row_word);
      end
    end

    phase = 0;
    while (phase < 7) begin
      case (phase % 5)
        0:       scale_pick = 13'd1000;
        1:       scale_pick = 13'd5000;
        2:       scale_pick = tmaf_pkg::REF_W'($urandom_range(5000, 1000));
        3:       scale_pick = tmaf_pkg::REF_W'($urandom_range(8191, 0));
        default: scale_pick = tmaf_pkg::REF_RESET;
      endcase
      write_scale(scale_pick);
      n_items = 45;
      if (phase == 4) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b1;
        n_items        = 300;
      end else begin
        send_idle_pct  = (phase % 4 == 1) ? 60 : (phase % 4 == 3) ? 21 : 0;
        recv_stall_pct = (phase % 4 == 2) ? 60 : (phase % 4 == 3) ? 21 : 0;
      end
      level   = $urandom_range(4095);
      ch_bias = $urandom_range(80, 20);
      for (int n = 0; n < n_items; n++) begin
        ch   = ($urandom_range(99) < ch_bias);
        pick = $urandom_range(9);
        if (pick == 0)      code = '0;
        else if (pick == 1) code = tmaf_pkg::SAMPLE_MAX;
        else if (pick < 6)  code = tmaf_pkg::SAMPLE_W'($urandom_range(4095));
        else begin
          v = level + int'($urandom_range(127)) - 64;
          if (v < 0)    v = 0;
          if (v > 4095) v = 4095;
          code = tmaf_pkg::SAMPLE_W'(v);
        end
        send_word(ch, code, 1'b0, no_word);
      end
      phase++;
    end

    in_valid_i <= 1'b0;
    while (awaited_means.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && awaited_means.size() == 0) begin
      $display("trimmed_mean_adc_filter_test: clean");
    end else begin
      $display("trimmed_mean_adc_filter_test: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/tmaf_pkg.sv
hdl/tmaf_front.sv
hdl/tmaf_queue.sv
hdl/tmaf_back.sv
hdl/trimmed_mean_adc_filter.sv
verif/trimmed_mean_adc_filter_test.sv
